// ===== design/evq_pkg.sv =====
package evq_pkg;

   localparam int NumSlotsDefault = 16;
   localparam int PriorityLevelsDefault = 4;

   typedef enum logic [1:0] {
      CMD_COMMIT = 2'd0,
      CMD_HANDLE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      OUT_NONE       = 3'd0,
      OUT_NORMAL     = 3'd1,
      OUT_REQUEST    = 3'd2,
      OUT_MATCHED    = 3'd3,
      OUT_DROPPED    = 3'd4,
      OUT_COMMIT_OK  = 3'd5,
      OUT_REFUSED    = 3'd6,
      OUT_QUERY      = 3'd7
   } outcome_type;

   localparam logic [2:0] KIND_NORMAL   = 3'd0;
   localparam logic [2:0] KIND_REQUEST  = 3'd1;
   localparam logic [2:0] KIND_WAITING  = 3'd2;
   localparam logic [2:0] KIND_RESPONSE = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  slot;
      logic [15:0] event_id;
      logic [7:0]  delay_priority;
      logic [2:0]  kind;
      logic [31:0] data_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [3:0]  dispatch_slot;
      logic [15:0] dispatch_id;
      logic [2:0]  dispatch_kind;
      logic [31:0] dispatch_tag;
      logic [3:0]  freed_request_slot;
      logic        slot_is_active;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request
      logic commit;     // perform the commit decision and write
      logic query;      // answer a query
      logic scan_start; // reset scan pointer for a new pass
      logic scan_step;  // examine the entry at the scan pointer
      logic match_step; // examine the entry at the match pointer
      logic remove;     // remove one list place (pointer in rm_sel)
      logic rm_sel;     // 0: scan place, 1: match place
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;      // scan pointer past the list
      logic hit_dispatch;  // entry at scan pointer dispatches (normal/request)
      logic hit_reply;     // entry at scan pointer is a reply
      logic is_normal;
      logic match_end;     // match pointer past the list
      logic match_found;   // entry at match pointer matches
      logic match_after;   // match place is later than scan place
      logic [1:0] command;
   } sts_type;

endpackage

// ===== design/event_queue_priority_age_match.sv =====
// Commit and query go through decode and done only; a handle step also runs up
// to PRIORITY_LEVELS passes of the single-entry scan and match walks over the
// ordered list.
// Throughput: one transaction at a time; busy stays high until the result shows.
// Synchronous reset clears the active flags, list length and controller state.
// Results cannot be stalled by the receiver.
module event_queue_priority_age_match #(
   parameter int NUM_SLOTS       = evq_pkg::NumSlotsDefault,
   parameter int PRIORITY_LEVELS = evq_pkg::PriorityLevelsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  evq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output evq_pkg::rsp_type rsp_data
);
   evq_pkg::ctl_type ctl;
   evq_pkg::sts_type sts;
   logic             valid;

   evq_control #(.PRIORITY_LEVELS(PRIORITY_LEVELS)) u_control (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .ctl(ctl),
      .busy(busy), .rsp_valid(valid)
   );

   evq_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .ctl(ctl), .sts(sts),
      .rsp_data(rsp_data)
   );

   assign rsp_strobe = valid;
endmodule

// ===== design/evq_datapath.sv =====
module evq_datapath #(
   parameter int NUM_SLOTS = evq_pkg::NumSlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  evq_pkg::req_type req_data,
   input  evq_pkg::ctl_type ctl,
   output evq_pkg::sts_type sts,
   output evq_pkg::rsp_type rsp_data
);
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LW = $clog2(NUM_SLOTS + 1);

   logic [15:0]   id_mem    [NUM_SLOTS];
   logic [7:0]    delay_mem [NUM_SLOTS];
   logic [2:0]    kind_mem  [NUM_SLOTS];
   logic [31:0]   tag_mem   [NUM_SLOTS];
   logic [IW-1:0] order_ff  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] active_ff;
   logic [LW-1:0] length_ff;

   evq_pkg::req_type req_ff;
   evq_pkg::rsp_type rsp_ff, rsp_in;
   logic [LW-1:0] scan_ff, match_ff;

   logic [IW-1:0] s_slot, m_slot, rm_slot;
   logic [LW-1:0] rm_pos;
   logic          slot_ok;
   logic [IW-1:0] req_slot;

   assign s_slot   = order_ff[scan_ff[IW-1:0]];
   assign m_slot   = order_ff[match_ff[IW-1:0]];
   assign rm_pos   = ctl.rm_sel ? match_ff : scan_ff;
   assign rm_slot  = order_ff[rm_pos[IW-1:0]];
   assign slot_ok  = {3'b0, req_ff.slot} < 7'(NUM_SLOTS);
   assign req_slot = IW'(req_ff.slot);

   always_comb begin
      sts.command      = req_ff.command;
      sts.scan_end     = scan_ff >= length_ff;
      sts.hit_dispatch = delay_mem[s_slot] == 8'd0 && kind_mem[s_slot] < evq_pkg::KIND_WAITING;
      sts.hit_reply    = delay_mem[s_slot] == 8'd0 && kind_mem[s_slot] > evq_pkg::KIND_WAITING;
      sts.is_normal    = kind_mem[s_slot] == evq_pkg::KIND_NORMAL;
      sts.match_end    = match_ff >= length_ff;
      sts.match_found  = kind_mem[m_slot] == evq_pkg::KIND_WAITING
                         && id_mem[m_slot] == id_mem[s_slot];
      sts.match_after  = match_ff > scan_ff;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctl.load) begin
         rsp_in = '0;
      end
      if (ctl.commit) begin
         if (!slot_ok || active_ff[req_slot] || length_ff >= LW'(NUM_SLOTS)) begin
            rsp_in.outcome = evq_pkg::OUT_REFUSED;
         end else begin
            rsp_in.outcome = evq_pkg::OUT_COMMIT_OK;
         end
      end
      if (ctl.query) begin
         rsp_in.outcome        = evq_pkg::OUT_QUERY;
         rsp_in.slot_is_active = slot_ok && active_ff[req_slot];
      end
      if (ctl.scan_step && (sts.hit_dispatch || sts.hit_reply)) begin
         rsp_in.dispatch_slot = 4'(s_slot);
         rsp_in.dispatch_id   = id_mem[s_slot];
         rsp_in.dispatch_kind = kind_mem[s_slot];
         rsp_in.dispatch_tag  = tag_mem[s_slot];
         if (sts.hit_reply) begin
            rsp_in.outcome = evq_pkg::OUT_DROPPED;
         end else if (sts.is_normal) begin
            rsp_in.outcome = evq_pkg::OUT_NORMAL;
         end else begin
            rsp_in.outcome = evq_pkg::OUT_REQUEST;
         end
      end
      if (ctl.match_step && !sts.match_end && sts.match_found) begin
         rsp_in.outcome            = evq_pkg::OUT_MATCHED;
         rsp_in.freed_request_slot = 4'(m_slot);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      if (ctl.commit && slot_ok && !active_ff[req_slot] && length_ff < LW'(NUM_SLOTS)) begin
         id_mem[req_slot]    <= req_ff.event_id;
         delay_mem[req_slot] <= req_ff.delay_priority;
         kind_mem[req_slot]  <= req_ff.kind;
         tag_mem[req_slot]   <= req_ff.data_tag;
      end
      if (ctl.scan_step && !sts.scan_end) begin
         if (delay_mem[s_slot] != 8'd0) begin
            delay_mem[s_slot] <= delay_mem[s_slot] - 8'd1;
         end else if (sts.hit_dispatch && !sts.is_normal) begin
            kind_mem[s_slot] <= evq_pkg::KIND_WAITING;
         end
      end
      if (ctl.remove) begin
         // Close the gap left by the removed place.
         for (int k = 0; k < NUM_SLOTS - 1; k++) begin
            if (LW'(k) >= rm_pos) begin
               order_ff[k] <= order_ff[k + 1];
            end
         end
      end else if (ctl.commit && slot_ok && !active_ff[req_slot]
                   && length_ff < LW'(NUM_SLOTS)) begin
         order_ff[length_ff[IW-1:0]] <= req_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         length_ff <= '0;
         scan_ff   <= '0;
         match_ff  <= '0;
      end else begin
         if (ctl.remove) begin
            active_ff[rm_slot] <= 1'b0;
            length_ff          <= length_ff - 1'b1;
         end else if (ctl.commit && slot_ok && !active_ff[req_slot]
                      && length_ff < LW'(NUM_SLOTS)) begin
            active_ff[req_slot] <= 1'b1;
            length_ff           <= length_ff + 1'b1;
         end
         if (ctl.scan_start) begin
            scan_ff <= '0;
         end else if (ctl.scan_step) begin
            // A hit holds the scan place for the match walk and the removal.
            if (!sts.hit_dispatch && !sts.hit_reply) begin
               scan_ff <= scan_ff + 1'b1;
            end
            match_ff <= '0;
         end else if (ctl.match_step && !sts.match_found) begin
            match_ff <= match_ff + 1'b1;
         end
      end
   end

   assign rsp_data = rsp_ff;
endmodule

// ===== design/evq_control.sv =====
module evq_control #(
   parameter int PRIORITY_LEVELS = evq_pkg::PriorityLevelsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  evq_pkg::sts_type sts,
   output evq_pkg::ctl_type ctl,
   output logic             busy,
   output logic             rsp_valid
);
   localparam int PW = $clog2(PRIORITY_LEVELS + 1);

   typedef enum logic [2:0] {
      IDLE, DECODE, SCAN, MATCH, REMOVE2, DONE
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic          rm_late_ff, rm_late_in;

   always_comb begin
      ctl        = '0;
      state_in   = state_ff;
      pass_in    = pass_ff;
      rm_late_in = rm_late_ff;
      unique case (state_ff)
         IDLE: begin
            if (start && !busy) begin
               ctl.load = 1'b1;
               state_in = DECODE;
            end
         end
         DECODE: begin
            unique case (evq_pkg::command_type'(sts.command))
               evq_pkg::CMD_COMMIT: begin
                  ctl.commit = 1'b1;
                  state_in   = DONE;
               end
               evq_pkg::CMD_HANDLE: begin
                  ctl.scan_start = 1'b1;
                  pass_in        = '0;
                  state_in       = SCAN;
               end
               evq_pkg::CMD_QUERY: begin
                  ctl.query = 1'b1;
                  state_in  = DONE;
               end
               default: state_in = DONE;
            endcase
         end
         SCAN: begin
            if (sts.scan_end) begin
               ctl.scan_start = 1'b1;
               pass_in        = pass_ff + 1'b1;
               if (pass_ff + 1'b1 >= PW'(PRIORITY_LEVELS)) begin
                  state_in = DONE;
               end
            end else begin
               ctl.scan_step = 1'b1;
               if (sts.hit_dispatch) begin
                  if (sts.is_normal) begin
                     ctl.remove = 1'b1;
                  end
                  state_in = DONE;
               end else if (sts.hit_reply) begin
                  // The datapath holds the scan place while the match walk runs.
                  state_in = MATCH;
               end
            end
         end
         MATCH: begin
            if (sts.match_end) begin
               ctl.remove = 1'b1;
               state_in   = DONE;
            end else if (sts.match_found) begin
               ctl.remove     = 1'b1;
               ctl.rm_sel     = sts.match_after;
               ctl.match_step = 1'b1;
               rm_late_in     = sts.match_after;
               state_in       = REMOVE2;
            end else begin
               ctl.match_step = 1'b1;
            end
         end
         REMOVE2: begin
            ctl.remove = 1'b1;
            ctl.rm_sel = !rm_late_ff;
            state_in   = DONE;
         end
         DONE: begin
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         pass_ff    <= '0;
         rm_late_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         rm_late_ff <= rm_late_in;
         rsp_valid  <= state_ff == DONE;
      end
   end

   assign busy = state_ff != IDLE || rsp_valid;
endmodule
